### design/bkps_pkg.sv
// Shared types, sizes and helper functions for the bitonic key/payload sorter.
// No dependencies; imported by every design module.
package bkps_pkg;

   // Block size; the comparator schedule and bank split assume a power of two.
   localparam int ITEMS      = 32;
   localparam int HALF       = ITEMS / 2;
   localparam int IDX_W      = (ITEMS > 1) ? $clog2(ITEMS) : 1;
   localparam int CNT_W      = $clog2(ITEMS + 1);
   localparam int BANK_DEPTH = HALF;
   localparam int BADDR_W    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int KEY_W      = 32;
   localparam int PAY_W      = 32;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } bkps_rec_type;

   // Command from the controller to the datapath, valid for one cycle.
   typedef struct packed {
      logic             wr_load;  // write the incoming record at idx_a
      logic             cmp_rd;   // read pair idx_a / idx_b for a compare-exchange
      logic             emit_rd;  // read record idx_a for output
      logic [IDX_W-1:0] idx_a;
      logic [IDX_W-1:0] idx_b;
      logic             asc;
      logic             last;
   } bkps_cmd_type;

   // Bank select: indices one bit apart always land in opposite banks.
   function automatic logic idx_bank(input logic [IDX_W-1:0] idx);
      return ^idx;
   endfunction

   function automatic logic [BADDR_W-1:0] idx_addr(input logic [IDX_W-1:0] idx);
      return BADDR_W'(idx >> 1);
   endfunction

endpackage

### design/bkps_ctrl.sv
// Sequencer for the bitonic sorter: load, comparator schedule, emit.
// Depends on bkps_pkg; drives the datapath through bkps_cmd_type.
module bkps_ctrl
   import bkps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         rsp_ready,
   input  logic         out_valid,
   output bkps_cmd_type cmd
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SORT = 2'd1;
   localparam logic [1:0] ST_GAP  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] dist_ff, dist_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic             final_ff, final_in;
   logic [IDX_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic             emit_pend_ff, emit_pend_in;
   logic [CNT_W-1:0] right;
   logic [CNT_W-1:0] size_dbl;
   logic             issue;

   assign right    = left_ff + dist_ff;
   assign size_dbl = size_ff << 1;
   assign issue    = !emit_pend_ff && (!out_valid || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      size_in      = size_ff;
      dist_in      = dist_ff;
      left_in      = left_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      final_in     = final_ff;
      emit_cnt_in  = emit_cnt_ff;
      emit_pend_in = 1'b0;
      req_ready    = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.idx_a = load_cnt_ff[IDX_W-1:0];
            if (req_valid) begin
               cmd.wr_load = 1'b1;
               if (load_cnt_ff == CNT_W'(ITEMS - 1)) begin
                  load_cnt_in = '0;
                  state_in    = ST_SORT;
                  i_in        = '0;
                  j_in        = '0;
                  left_in     = '0;
                  size_in     = CNT_W'(2);
                  if (ITEMS > 2) begin
                     dist_in  = CNT_W'(1);
                     final_in = 1'b0;
                  end else begin
                     dist_in  = CNT_W'(ITEMS >> 1);
                     final_in = 1'b1;
                  end
               end else begin
                  load_cnt_in = load_cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_SORT: begin
            cmd.cmp_rd = (right < CNT_W'(ITEMS));
            cmd.idx_a  = left_ff[IDX_W-1:0];
            cmd.idx_b  = right[IDX_W-1:0];
            cmd.asc    = final_ff || ((left_ff & size_ff) == '0);
            if (i_ff == IDX_W'(HALF - 1)) begin
               state_in = ST_GAP;
            end else begin
               i_in = i_ff + IDX_W'(1);
               if (j_ff + CNT_W'(1) == dist_ff) begin
                  j_in    = '0;
                  left_in = left_ff + dist_ff + CNT_W'(1);
               end else begin
                  j_in    = j_ff + CNT_W'(1);
                  left_in = left_ff + CNT_W'(1);
               end
            end
         end
         ST_GAP: begin
            // last write-back of the stage lands here
            i_in     = '0;
            j_in     = '0;
            left_in  = '0;
            state_in = ST_SORT;
            if (dist_ff > CNT_W'(1)) begin
               dist_in = dist_ff >> 1;
            end else if (final_ff) begin
               state_in    = ST_EMIT;
               emit_cnt_in = '0;
            end else if (size_dbl < CNT_W'(ITEMS)) begin
               size_in = size_dbl;
               dist_in = size_ff;
            end else begin
               final_in = 1'b1;
               dist_in  = CNT_W'(ITEMS >> 1);
            end
         end
         ST_EMIT: begin
            cmd.idx_a = emit_cnt_ff;
            cmd.last  = (emit_cnt_ff == IDX_W'(ITEMS - 1));
            if (issue) begin
               cmd.emit_rd  = 1'b1;
               emit_pend_in = 1'b1;
               if (emit_cnt_ff == IDX_W'(ITEMS - 1)) begin
                  state_in = ST_LOAD;
               end else begin
                  emit_cnt_in = emit_cnt_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_cnt_ff  <= '0;
         size_ff      <= '0;
         dist_ff      <= '0;
         left_ff      <= '0;
         j_ff         <= '0;
         i_ff         <= '0;
         final_ff     <= 1'b0;
         emit_cnt_ff  <= '0;
         emit_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         size_ff      <= size_in;
         dist_ff      <= dist_in;
         left_ff      <= left_in;
         j_ff         <= j_in;
         i_ff         <= i_in;
         final_ff     <= final_in;
         emit_cnt_ff  <= emit_cnt_in;
         emit_pend_ff <= emit_pend_in;
      end
   end

endmodule

### design/bkps_datapath.sv
// Record banks, compare-exchange unit and output register of the sorter.
// Depends on bkps_pkg; follows commands from bkps_ctrl.
module bkps_datapath
   import bkps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bkps_cmd_type     cmd,
   input  logic [KEY_W-1:0] req_key,
   input  logic [PAY_W-1:0] req_payload,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [KEY_W-1:0] rsp_key_res,
   output logic [PAY_W-1:0] rsp_payload_res,
   output logic             rsp_last
);

   bkps_rec_type bank0_mem [BANK_DEPTH];
   bkps_rec_type bank1_mem [BANK_DEPTH];

   bkps_rec_type     rd0_ff, rd1_ff;
   logic             cmp_pend_ff, emit_pend_ff;
   logic             a_bank_ff;
   logic [IDX_W-1:0] idx_a_ff, idx_b_ff;
   logic             asc_ff, last_ff;

   logic             a_bank;
   logic [BADDR_W-1:0] rd_addr0, rd_addr1;
   bkps_rec_type     rec_l, rec_r, new_l, new_r, in_rec;
   logic             swap;
   logic             wr0, wr1;
   logic [BADDR_W-1:0] wr_addr0, wr_addr1;
   bkps_rec_type     wr_data0, wr_data1;

   bkps_rec_type     out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_last_ff, out_last_in;

   assign a_bank         = idx_bank(cmd.idx_a);
   assign in_rec.key     = req_key;
   assign in_rec.payload = req_payload;

   always_comb begin
      if (cmd.emit_rd || !a_bank) begin
         rd_addr0 = idx_addr(cmd.idx_a);
      end else begin
         rd_addr0 = idx_addr(cmd.idx_b);
      end
      if (cmd.emit_rd || a_bank) begin
         rd_addr1 = idx_addr(cmd.idx_a);
      end else begin
         rd_addr1 = idx_addr(cmd.idx_b);
      end
   end

   // compare-exchange on the registered pair
   always_comb begin
      rec_l = a_bank_ff ? rd1_ff : rd0_ff;
      rec_r = a_bank_ff ? rd0_ff : rd1_ff;
      swap  = asc_ff ? (rec_l.key > rec_r.key) : (rec_l.key < rec_r.key);
      new_l = swap ? rec_r : rec_l;
      new_r = swap ? rec_l : rec_r;
   end

   always_comb begin
      wr0      = 1'b0;
      wr1      = 1'b0;
      wr_addr0 = idx_addr(cmd.idx_a);
      wr_addr1 = idx_addr(cmd.idx_a);
      wr_data0 = in_rec;
      wr_data1 = in_rec;
      if (cmd.wr_load) begin
         wr0 = !a_bank;
         wr1 = a_bank;
      end else if (cmp_pend_ff && swap) begin
         wr0      = 1'b1;
         wr1      = 1'b1;
         wr_addr0 = a_bank_ff ? idx_addr(idx_b_ff) : idx_addr(idx_a_ff);
         wr_addr1 = a_bank_ff ? idx_addr(idx_a_ff) : idx_addr(idx_b_ff);
         wr_data0 = a_bank_ff ? new_r : new_l;
         wr_data1 = a_bank_ff ? new_l : new_r;
      end
   end

   always_ff @(posedge clock) begin
      if (wr0) begin
         bank0_mem[wr_addr0] <= wr_data0;
      end
      if (wr1) begin
         bank1_mem[wr_addr1] <= wr_data1;
      end
      rd0_ff <= bank0_mem[rd_addr0];
      rd1_ff <= bank1_mem[rd_addr1];
   end

   always_ff @(posedge clock) begin
      a_bank_ff <= a_bank;
      idx_a_ff  <= cmd.idx_a;
      idx_b_ff  <= cmd.idx_b;
      asc_ff    <= cmd.asc;
      last_ff   <= cmd.last;
   end

   always_comb begin
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (emit_pend_ff) begin
         out_in       = a_bank_ff ? rd1_ff : rd0_ff;
         out_last_in  = last_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         cmp_pend_ff  <= 1'b0;
         emit_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cmp_pend_ff  <= cmd.cmp_rd;
         emit_pend_ff <= cmd.emit_rd;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_key_res     = out_ff.key;
   assign rsp_payload_res = out_ff.payload;
   assign rsp_last        = out_last_ff;

endmodule

### design/bitonic_key_payload_sorter.sv
// Top level of the bitonic key/payload sorter: controller plus datapath.
// Depends on bkps_pkg, bkps_ctrl and bkps_datapath.
//
// Sorts blocks of ITEMS (32) records, each a 32-bit key with a 32-bit payload,
// ascending by key with the iterative bitonic network; records with equal keys
// swap only when strictly out of order, so ties land where the network puts
// them. Feed exactly ITEMS records on req_*, one transfer per cycle; the block
// then sorts and returns the ITEMS records on rsp_*, rsp_last marking the final
// one. Records live in two banks split by index parity, each with one read and
// one write per cycle, so each compare-exchange reads one record from each bank
// and writes the swapped pair back in the next cycle, one comparator per cycle.
// A block is loaded first, then runs L(L+1)/2 network stages (L = log2 ITEMS),
// each of ITEMS/2 compare-exchanges followed by a gap state that drains the
// write-back; then the records are read out one at a time, a new output read
// issued only when none is in flight and the output register is free or the
// sink is taking it. Loading of the next block opens as soon as the last
// output read is issued, while the last record may still wait in the output
// register.
module bitonic_key_payload_sorter
   import bkps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [KEY_W-1:0] req_key,
   input  logic [PAY_W-1:0] req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [KEY_W-1:0] rsp_key_res,
   output logic [PAY_W-1:0] rsp_payload_res,
   output logic             rsp_last
);

   bkps_cmd_type cmd;

   // sequence load, network stages and output reads
   bkps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .out_valid (rsp_valid),
      .cmd       (cmd)
   );

   // hold records, run compare-exchanges, hold the outgoing transfer
   bkps_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_key_res     (rsp_key_res),
      .rsp_payload_res (rsp_payload_res),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // no input transfer while the network runs
   a_no_load_in_sort: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp_rd |-> !req_ready)
      else $error("input accepted during sort");

   // an output read never overwrites a record still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_rd |-> (!rsp_valid || rsp_ready))
      else $error("output register overrun");

   // one output read in flight at a time
   a_emit_spaced: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_rd |=> !cmd.emit_rd)
      else $error("back-to-back output reads");
`endif

endmodule

### dv/bitonic_key_payload_sorter_checker.sv
`timescale 1ns / 1ps
// Checker for the bitonic key/payload sorter: watches both channels, predicts sorted blocks.
// Depends on bkps_pkg for sizes and the record type.
module bitonic_key_payload_sorter_checker
   import bkps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [KEY_W-1:0] req_key,
   input  logic [PAY_W-1:0] req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [KEY_W-1:0] rsp_key_res,
   input  logic [PAY_W-1:0] rsp_payload_res,
   input  logic             rsp_last,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      bkps_rec_type rec;
      logic         last;
   } sorted_rec_type;

   localparam int SHOWN_MAX = 10;

   logic [KEY_W-1:0] held_key[ITEMS];
   logic [PAY_W-1:0] held_payload[ITEMS];
   int               held_count;
   sorted_rec_type   sorted_due[$];
   int               mismatches;
   int               rsp_seen;
   sorted_rec_type   want;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      held_count    = 0;
      mismatches    = 0;
      rsp_seen      = 0;
   end

   task automatic order_pair(input int lo, input int hi, input logic up);
      logic [KEY_W-1:0] k;
      logic [PAY_W-1:0] p;
      if (up ? (held_key[lo] > held_key[hi]) : (held_key[lo] < held_key[hi])) begin
         k                = held_key[lo];
         p                = held_payload[lo];
         held_key[lo]     = held_key[hi];
         held_payload[lo] = held_payload[hi];
         held_key[hi]     = k;
         held_payload[hi] = p;
      end
   endtask

   task automatic bitonic_pass(input int size, input int span, input logic merge);
      int lo;
      int hi;
      for (int i = 0; i < ITEMS / 2; i++) begin
         lo = 2 * i - (i % span);
         hi = lo + span;
         if (hi < ITEMS)
            order_pair(lo, hi, merge ? 1'b1 : (((lo / size) % 2) == 0));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         sorted_due.delete();
      end else begin
         // check the result first: a block finished at this edge cannot emit yet
         if (rsp_valid && rsp_ready) begin
            if (sorted_due.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MAX)
                  $display("[%0t] unexpected result key=%h payload=%h last=%b",
                           $realtime, rsp_key_res, rsp_payload_res, rsp_last);
            end else begin
               want = sorted_due.pop_front();
               if (rsp_key_res !== want.rec.key || rsp_payload_res !== want.rec.payload ||
                   rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MAX)
                     $display(
                        "[%0t] result %0d: exp key=%h pay=%h last=%b, got key=%h pay=%h last=%b",
                        $realtime, rsp_seen, want.rec.key, want.rec.payload, want.last,
                        rsp_key_res, rsp_payload_res, rsp_last);
               end
            end
            rsp_seen++;
         end
         if (req_valid && req_ready) begin
            held_key[held_count]     = req_key;
            held_payload[held_count] = req_payload;
            held_count++;
            if (held_count == ITEMS) begin
               for (int size = 2; size < ITEMS; size = size * 2)
                  for (int span = size / 2; span > 0; span = span / 2)
                     bitonic_pass(size, span, 1'b0);
               for (int span = ITEMS / 2; span > 0; span = span / 2)
                  bitonic_pass(1, span, 1'b1);
               for (int k = 0; k < ITEMS; k++) begin
                  want.rec.key     = held_key[k];
                  want.rec.payload = held_payload[k];
                  want.last        = (k == ITEMS - 1);
                  sorted_due.push_back(want);
               end
               held_count = 0;
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= sorted_due.size();
   end

endmodule

### dv/bitonic_key_payload_sorter_tb.sv
`timescale 1ns / 1ps
// Top of the sorter testbench: clock, reset, record stimulus, sink stalls and verdict.
// Depends on bkps_pkg, bitonic_key_payload_sorter and bitonic_key_payload_sorter_checker.
module bitonic_key_payload_sorter_tb
   import bkps_pkg::*;
();

   // Sink holds off this long after reset, so the first block sorts, waits
   // on the output, and the sender stalls against a full block.
   localparam int HOLD_CYCLES   = 800;
   localparam int RANDOM_BLOCKS = 8;
   localparam int TAIL_CYCLES   = 40;

   typedef enum int {
      FILL_RANDOM,
      FILL_TIES,
      FILL_ASCENDING,
      FILL_DESCENDING,
      FILL_CONSTANT
   } fill_kind_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   logic [KEY_W-1:0] req_key     = '0;
   logic [PAY_W-1:0] req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   logic [KEY_W-1:0] rsp_key_res;
   logic [PAY_W-1:0] rsp_payload_res;
   logic             rsp_last;
   int               fail_count;
   int               pending_count;

   logic [KEY_W-1:0] blk_key[ITEMS];
   logic [PAY_W-1:0] blk_payload[ITEMS];
   logic             burst_mode;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bitonic_key_payload_sorter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_res     (rsp_key_res),
      .rsp_payload_res (rsp_payload_res),
      .rsp_last        (rsp_last)
   );

   bitonic_key_payload_sorter_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_res     (rsp_key_res),
      .rsp_payload_res (rsp_payload_res),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   // Offer one record and hold it until the transfer. Valid is only dropped
   // when a gap follows, so back-to-back records keep valid high.
   task automatic send_record(input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p);
      int gap;
      int r;
      r   = $urandom_range(0, 15);
      gap = 0;
      if (!burst_mode) begin
         if (r >= 14)
            gap = $urandom_range(10, 60);
         else if (r >= 8)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_key     <= k;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_block();
      for (int i = 0; i < ITEMS; i++)
         send_record(blk_key[i], blk_payload[i]);
   endtask

   // Sink: hold off long once, then stall at random with idle-free stretches.
   initial begin : sink
      int stall;
      int steady;
      int r;
      stall  = 0;
      steady = 0;
      while (reset) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (steady > 0)
               steady--;
            else if (r < 20)
               stall = $urandom_range(1, 3);
            else if (r < 23)
               stall = $urandom_range(15, 60);
            else if (r == 99)
               steady = $urandom_range(50, 150);
         end
      end
   end

   // Run limit: far beyond the slowest legal run of all blocks.
   initial begin : watchdog
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      fill_kind_type    kind;
      logic [KEY_W-1:0] base;
      logic [KEY_W-1:0] step;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed block: field extremes, alternating bit patterns, ties at
      // both ends of the key range, a run of equal keys and a reversed tail.
      burst_mode = 1'b1;
      for (int i = 0; i < ITEMS; i++) begin
         case (i)
            0:       begin blk_key[i] = 32'h0000_0000; blk_payload[i] = 32'h0000_0000; end
            1:       begin blk_key[i] = 32'hFFFF_FFFF; blk_payload[i] = 32'hFFFF_FFFF; end
            2:       begin blk_key[i] = 32'h0000_0000; blk_payload[i] = 32'hFFFF_FFFF; end
            3:       begin blk_key[i] = 32'hFFFF_FFFF; blk_payload[i] = 32'h0000_0000; end
            4:       begin blk_key[i] = 32'h5555_5555; blk_payload[i] = 32'hAAAA_AAAA; end
            5:       begin blk_key[i] = 32'hAAAA_AAAA; blk_payload[i] = 32'h5555_5555; end
            6:       begin blk_key[i] = 32'h0000_0001; blk_payload[i] = 32'h8000_0000; end
            7:       begin blk_key[i] = 32'hFFFF_FFFE; blk_payload[i] = 32'h0000_0001; end
            8:       begin blk_key[i] = 32'h8000_0000; blk_payload[i] = 32'h7FFF_FFFF; end
            9:       begin blk_key[i] = 32'h7FFF_FFFF; blk_payload[i] = 32'h8000_0000; end
            10, 11, 12, 13, 14, 15:
                     begin blk_key[i] = 32'h0000_1234; blk_payload[i] = i; end
            default: begin blk_key[i] = (31 - i) * 32'h0800_0001; blk_payload[i] = i; end
         endcase
      end
      send_block();

      // Random blocks: each fill kind once, then random or tied keys only.
      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         if (b < 5)
            kind = fill_kind_type'(b);
         else
            kind = ($urandom_range(0, 1) == 0) ? FILL_RANDOM : FILL_TIES;
         burst_mode = ($urandom_range(0, 3) == 0);
         base       = $urandom;
         step       = $urandom_range(1, 32'h0400_0000);
         for (int i = 0; i < ITEMS; i++) begin
            case (kind)
               FILL_RANDOM:     blk_key[i] = $urandom;
               FILL_TIES:       blk_key[i] = (base & 32'hFFFF_FFF0) | $urandom_range(0, 3);
               FILL_ASCENDING:  blk_key[i] = i * step;
               FILL_DESCENDING: blk_key[i] = (ITEMS - 1 - i) * step;
               default:         blk_key[i] = base;
            endcase
            blk_payload[i] = $urandom;
         end
         send_block();
      end
      req_valid <= 1'b0;

      // Drain: let the checker count the last block, wait for every sorted
      // record, then let the block settle.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### bitonic_key_payload_sorter.f
design/bkps_pkg.sv
design/bkps_ctrl.sv
design/bkps_datapath.sv
design/bitonic_key_payload_sorter.sv
dv/bitonic_key_payload_sorter_checker.sv
dv/bitonic_key_payload_sorter_tb.sv
